// File: rtl/src_pkg.sv
`timescale 1ns / 1ps

package src_pkg;

    // Item kinds carried on s_tuser
    localparam logic [1:0] KIND_PROBE  = 2'd0;
    localparam logic [1:0] KIND_STORE  = 2'd1;
    localparam logic [1:0] KIND_NEWAGE = 2'd2;
    localparam logic [1:0] KIND_CLEAR  = 2'd3;

    // Stored bound codes
    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;

    localparam int KEY_W   = 64;
    localparam int SCORE_W = 16;
    localparam int DEPTH_W = 6;
    localparam int AGE_W   = 16;
    localparam int BOUND_W = 2;
    localparam int MOVE_W  = 16;
    localparam int KIND_W  = 2;

    localparam int S_TDATA_W = 136;
    localparam int M_TDATA_W = 40;

    // Input item fields, highest bits first in s_tdata
    typedef struct packed {
        logic [MOVE_W-1:0]         move_code;
        logic [BOUND_W-1:0]        bound_kind;
        logic signed [SCORE_W-1:0] window_high;
        logic signed [SCORE_W-1:0] window_low;
        logic [DEPTH_W-1:0]        ply_depth;
        logic signed [SCORE_W-1:0] entry_score;
        logic [KEY_W-1:0]          position_key;
    } item_t;

    // One table slot
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic signed [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0]        depth;
        logic [AGE_W-1:0]          age;
        logic [BOUND_W-1:0]        bound;
        logic [MOVE_W-1:0]         move;
    } slot_t;

    // Controller to datapath
    typedef struct packed {
        logic load;    // take the input item, start the slot read
        logic exec;    // carry out the held item this cycle
        logic clr_wr;  // write an empty slot at the sweep index
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;      // kind of the held item
        logic              out_free;  // result register can take an item
        logic              clr_last;  // sweep index at the last slot
    } sts_t;

endpackage

// File: rtl/src_ctrl.sv
`timescale 1ns / 1ps

module src_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  src_pkg::sts_t sts,
    output src_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register; reset starts a clearing sweep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // a probe waits for room in the result register
                if (sts.kind != src_pkg::KIND_PROBE || sts.out_free) begin
                    cmd.exec = 1'b1;
                    if (sts.kind == src_pkg::KIND_CLEAR) begin
                        state_next = ST_CLEAR;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// File: rtl/src_dp.sv
`timescale 1ns / 1ps

module src_dp #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [src_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [src_pkg::KIND_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [src_pkg::M_TDATA_W-1:0]   m_tdata,
    input  src_pkg::cmd_t                   cmd,
    output src_pkg::sts_t                   sts
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    src_pkg::slot_t mem [TABLE_ENTRIES];

    src_pkg::item_t                 in_item;
    src_pkg::item_t                 item_reg;
    logic [src_pkg::KIND_W-1:0]     kind_reg;
    src_pkg::slot_t                 slot_reg;
    logic [src_pkg::AGE_W-1:0]      age_reg;
    logic [src_pkg::AGE_W-1:0]      age_next;
    logic [IDX_W-1:0]               clr_idx_reg;
    logic [IDX_W-1:0]               clr_idx_next;
    logic                           m_tvalid_reg;
    logic                           m_tvalid_next;
    logic [src_pkg::M_TDATA_W-1:0]  m_tdata_reg;
    logic [src_pkg::M_TDATA_W-1:0]  m_tdata_next;

    logic [IDX_W-1:0]   rd_idx;
    logic [IDX_W-1:0]   item_idx;
    logic               match;
    logic               deep_enough;
    logic               bound_ok;
    logic               cut;
    logic               replace;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    src_pkg::slot_t     wr_slot;
    logic signed [src_pkg::SCORE_W-1:0] out_score;
    logic [src_pkg::MOVE_W-1:0]         out_move;

    assign in_item  = src_pkg::item_t'(s_tdata);
    assign rd_idx   = in_item.position_key[IDX_W-1:0];
    assign item_idx = item_reg.position_key[IDX_W-1:0];

    // Held item and its slot, read at acceptance
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= in_item;
            kind_reg <= s_tuser;
            slot_reg <= mem[rd_idx];
        end
    end

    // Probe decision
    always_comb begin
        match       = (slot_reg.key == item_reg.position_key);
        deep_enough = (slot_reg.depth >= item_reg.ply_depth);
        case (slot_reg.bound)
            src_pkg::BOUND_EXACT: bound_ok = 1'b1;
            src_pkg::BOUND_LOWER: bound_ok = (slot_reg.score >= item_reg.window_high);
            src_pkg::BOUND_UPPER: bound_ok = (slot_reg.score <= item_reg.window_low);
            default:              bound_ok = 1'b0;
        endcase
        cut       = match && deep_enough && bound_ok;
        out_score = cut ? slot_reg.score : '0;
        out_move  = match ? slot_reg.move : '0;
    end

    // Replacement rule for a store
    assign replace = (slot_reg.key == '0) || match
                   || (item_reg.ply_depth >= slot_reg.depth)
                   || (slot_reg.age < age_reg);

    // Single write port: sweep writes empty slots, a store writes the new one
    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = item_idx;
        wr_slot = '0;
        if (cmd.clr_wr) begin
            wr_en  = 1'b1;
            wr_idx = clr_idx_reg;
        end else if (cmd.exec && kind_reg == src_pkg::KIND_STORE && replace) begin
            wr_en         = 1'b1;
            wr_slot.key   = item_reg.position_key;
            wr_slot.score = item_reg.entry_score;
            wr_slot.depth = item_reg.ply_depth;
            wr_slot.age   = age_reg;
            wr_slot.bound = item_reg.bound_kind;
            wr_slot.move  = item_reg.move_code;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_slot;
        end
    end

    // Search age and sweep index
    always_comb begin
        age_next     = age_reg;
        clr_idx_next = clr_idx_reg;
        if (cmd.clr_wr) begin
            clr_idx_next = clr_idx_reg + 1'b1;
        end
        if (cmd.exec && kind_reg == src_pkg::KIND_NEWAGE && age_reg != '1) begin
            age_next = age_reg + 1'b1;
        end
        if (cmd.exec && kind_reg == src_pkg::KIND_CLEAR) begin
            age_next     = '0;
            clr_idx_next = '0;
        end
    end

    // Result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (cmd.exec && kind_reg == src_pkg::KIND_PROBE) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, out_move, match, out_score, cut};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_reg      <= '0;
            clr_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            age_reg      <= age_next;
            clr_idx_reg  <= clr_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign sts.kind     = kind_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign sts.clr_last = (clr_idx_reg == '1);

endmodule

// File: rtl/search_result_cache_core.sv
`timescale 1ns / 1ps
// Direct-mapped cache of search results, indexed by the low key bits.
// Input channel (s_): one item per handshake; s_tuser carries the kind
// (probe, store, new search, clear) and s_tdata the key and payload.
// Result channel (m_): one item per probe only, with cutoff, score,
// key-match flag and move; stores, new search and clear give no item.
// A new item is taken only once the held one is done. The accept cycle
// reads the slot into a register, then the exec state compares and writes
// back through the single write port of the slot memory. A probe result
// is on m_tvalid the cycle after the exec state.
// Reset and clear: all TABLE_ENTRIES slots (4096 at the default) are swept,
// one slot per cycle; s_tready stays low during the sweep. The search age
// returns to zero.
// Receiver stall: the result register holds its item; the next item is
// still taken, and a following probe waits until the register frees up.
module search_result_cache_core #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // position_key[63:0], entry_score[79:64], ply_depth[85:80],
    // window_low[101:86], window_high[117:102], bound_kind[119:118],
    // move_code[135:120]
    input  logic [135:0]  s_tdata,
    // kind[1:0]
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // cutoff[0], found_score[16:1], move_found[17], found_move[33:18], zeros[39:34]
    output logic [39:0]   m_tdata
);

    src_pkg::cmd_t cmd;
    src_pkg::sts_t sts;

    src_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    src_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int  TBL_N       = 4096;
    localparam int  IDX_W       = $clog2(TBL_N);
    localparam int  RAND_ITEMS  = 1400;
    localparam int  CALM_ITEMS  = 250;      // tail of the random part with no idling
    localparam int  AGE_MAX     = 65535;
    localparam longint CYCLE_LIMIT = 1500000;
    // Bound code outside the three known ones
    localparam logic [1:0] BOUND_ODD = 2'd3;

    // Result item as packed on m_tdata, lowest field last
    typedef struct packed {
        logic [5:0]         pad;
        logic [15:0]        found_move;
        logic               move_found;
        logic signed [15:0] found_score;
        logic               cutoff;
    } probe_reply_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = src_pkg::KIND_PROBE;
    logic         m_tvalid;
    logic         m_tready = 1'b1;
    logic [39:0]  m_tdata;

    search_result_cache_core #(
        .TABLE_ENTRIES(TBL_N)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the slot memory and the search age
    logic [src_pkg::KEY_W-1:0]          tbl_key   [TBL_N];
    logic signed [src_pkg::SCORE_W-1:0] tbl_score [TBL_N];
    logic [src_pkg::DEPTH_W-1:0]        tbl_depth [TBL_N];
    logic [src_pkg::AGE_W-1:0]          tbl_age   [TBL_N];
    logic [src_pkg::BOUND_W-1:0]        tbl_bound [TBL_N];
    logic [src_pkg::MOVE_W-1:0]         tbl_move  [TBL_N];
    logic [src_pkg::AGE_W-1:0]          search_age;

    probe_reply_t pending_replies[$];

    bit     idle_en = 1'b1;
    int     errors = 0;
    int     items_sent = 0;
    int     replies_checked = 0;
    int     clears_done = 0;
    int     rx_left = 0;
    longint cycle_count = 0;
    logic [src_pkg::KEY_W-1:0] last_store_key = '0;

    // Slots and tags that most random keys are drawn from, so that keys collide
    logic [IDX_W-1:0] hot_slots [8] = '{12'h000, 12'hFFF, 12'h5A5, 12'h001,
                                        12'h800, 12'h3C3, 12'h7FE, 12'hA5A};
    logic [src_pkg::KEY_W-IDX_W-1:0] hot_tags [4] = '{'0, '1, 52'h1, 52'h9_C3A5_0F1E_2D4B};

    // Back to the empty table
    task automatic wipe_shadow();
        for (int i = 0; i < TBL_N; i++) begin
            tbl_key[i]   = '0;
            tbl_score[i] = '0;
            tbl_depth[i] = '0;
            tbl_age[i]   = '0;
            tbl_bound[i] = src_pkg::BOUND_EXACT;
            tbl_move[i]  = '0;
        end
        search_age = '0;
    endtask

    // Apply one accepted item to the shadow table, queue the reply of a probe
    task automatic cache_step(input logic [1:0] kind, input src_pkg::item_t it);
        logic [IDX_W-1:0]                   idx;
        logic signed [src_pkg::SCORE_W-1:0] sc;
        probe_reply_t                       r;
        idx = it.position_key[IDX_W-1:0];
        case (kind)
            src_pkg::KIND_PROBE: begin
                r = '0;
                if (tbl_key[idx] == it.position_key) begin
                    r.move_found = 1'b1;
                    r.found_move = tbl_move[idx];
                    if (tbl_depth[idx] >= it.ply_depth) begin
                        sc = tbl_score[idx];
                        if (tbl_bound[idx] == src_pkg::BOUND_EXACT ||
                            (tbl_bound[idx] == src_pkg::BOUND_LOWER &&
                             $signed(sc) >= $signed(it.window_high)) ||
                            (tbl_bound[idx] == src_pkg::BOUND_UPPER &&
                             $signed(sc) <= $signed(it.window_low))) begin
                            r.cutoff      = 1'b1;
                            r.found_score = sc;
                        end
                    end
                end
                pending_replies.insert(pending_replies.size(), r);
            end
            src_pkg::KIND_STORE: begin
                if (tbl_key[idx] == '0 || tbl_key[idx] == it.position_key ||
                    it.ply_depth >= tbl_depth[idx] || tbl_age[idx] < search_age) begin
                    tbl_key[idx]   = it.position_key;
                    tbl_score[idx] = it.entry_score;
                    tbl_depth[idx] = it.ply_depth;
                    tbl_bound[idx] = it.bound_kind;
                    tbl_move[idx]  = it.move_code;
                    tbl_age[idx]   = search_age;
                end
            end
            src_pkg::KIND_NEWAGE: begin
                if (search_age != AGE_MAX[src_pkg::AGE_W-1:0])
                    search_age = search_age + 1'b1;
            end
            src_pkg::KIND_CLEAR: begin
                wipe_shadow();
                clears_done++;
            end
            default: begin
            end
        endcase
    endtask

    function automatic src_pkg::item_t make_item(input logic [63:0] key,
                                                 input logic [15:0] score,
                                                 input logic [5:0] depth,
                                                 input logic [15:0] lo,
                                                 input logic [15:0] hi,
                                                 input logic [1:0] bound,
                                                 input logic [15:0] move);
        src_pkg::item_t it;
        it.position_key = key;
        it.entry_score  = score;
        it.ply_depth    = depth;
        it.window_low   = lo;
        it.window_high  = hi;
        it.bound_kind   = bound;
        it.move_code    = move;
        return it;
    endfunction

    // Drive one item, wait for its handshake, then update the shadow table.
    // Called right after a rising edge; valid stays high into the next item.
    task automatic send_item(input logic [1:0] kind, input src_pkg::item_t it);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= it;
        do @(posedge aclk); while (!s_tready);
        cache_step(kind, it);
        items_sent++;
    endtask

    task automatic probe(input logic [63:0] key, input logic [5:0] depth,
                         input logic [15:0] lo, input logic [15:0] hi);
        send_item(src_pkg::KIND_PROBE,
                  make_item(key, 16'($urandom), depth, lo, hi, 2'($urandom),
                            16'($urandom)));
    endtask

    task automatic store(input logic [63:0] key, input logic [15:0] score,
                         input logic [5:0] depth, input logic [1:0] bound,
                         input logic [15:0] move);
        send_item(src_pkg::KIND_STORE,
                  make_item(key, score, depth, 16'($urandom), 16'($urandom), bound, move));
        last_store_key = key;
    endtask

    task automatic control(input logic [1:0] kind);
        send_item(kind, make_item({$urandom, $urandom}, 16'($urandom), 6'($urandom),
                                  16'($urandom), 16'($urandom), 2'($urandom),
                                  16'($urandom)));
    endtask

    // Random field values with the extremes weighted up
    function automatic logic [15:0] rand_score();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [5:0] rand_depth();
        case ($urandom_range(0, 9))
            0:       return 6'd0;
            1:       return 6'd63;
            default: return 6'($urandom);
        endcase
    endfunction

    function automatic logic [63:0] rand_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        else if (r < 18)
            return {$urandom, $urandom};
        else
            return {hot_tags[$urandom_range(0, 3)], hot_slots[$urandom_range(0, 7)]};
    endfunction

    // Probes into a fresh table: key zero matches an empty slot
    task automatic test_empty_probes();
        probe(64'd0, 6'd0, 16'h0000, 16'h0000);
        probe(64'd0, 6'd1, 16'h7FFF, 16'h8000);
        probe('1, 6'd0, 16'h8000, 16'h7FFF);
        probe(64'h0000_0000_0000_1000, 6'd0, 16'h0000, 16'h0000);
    endtask

    // Field extremes and every bound code
    task automatic test_bounds_and_extremes();
        store('1, 16'h7FFF, 6'd63, src_pkg::BOUND_LOWER, 16'hFFFF);
        probe('1, 6'd63, 16'h0000, 16'h7FFF);       // score >= beta
        probe('1, 6'd0, 16'h8000, 16'h8000);
        store('1, 16'h8000, 6'd63, src_pkg::BOUND_UPPER, 16'h0000);
        probe('1, 6'd10, 16'h8000, 16'h7FFF);       // score <= alpha at the bottom
        probe('1, 6'd10, 16'h8000 + 16'd0, 16'h8000);
        store('1, 16'h1234, 6'd20, src_pkg::BOUND_EXACT, 16'hA5C3);
        probe('1, 6'd21, 16'h0000, 16'h0000);       // too shallow
        probe('1, 6'd20, 16'h7FFF, 16'h8000);
        store('1, 16'h0000, 6'd20, BOUND_ODD, 16'h5A3C); // odd code never cuts
        probe('1, 6'd0, 16'h7FFF, 16'h8000);
        store('1, 16'hFFFF, 6'd20, src_pkg::BOUND_LOWER, 16'h0001);
        probe('1, 6'd20, 16'h0000, 16'h0000);       // -1 below beta 0
    endtask

    // A slot written with key zero still counts as empty
    task automatic test_zero_key();
        store(64'd0, 16'h0055, 6'd40, src_pkg::BOUND_EXACT, 16'h00AA);
        probe(64'd0, 6'd40, 16'h0000, 16'h0000);
        store(64'h0000_0000_0000_3000, 16'h0066, 6'd5, src_pkg::BOUND_EXACT, 16'h0077);
        probe(64'h0000_0000_0000_3000, 6'd0, 16'h0000, 16'h0000);
        probe(64'd0, 6'd0, 16'h0000, 16'h0000);
    endtask

    // Depth-then-age replacement on one slot
    task automatic test_replacement();
        store(64'hCAFE_0000_0000_0123, 16'd100, 6'd20, src_pkg::BOUND_EXACT, 16'd1);
        // shallower, kept out
        store(64'hBEEF_0000_0000_0123, 16'd200, 6'd10, src_pkg::BOUND_EXACT, 16'd2);
        probe(64'hCAFE_0000_0000_0123, 6'd0, 16'h0000, 16'h0000);
        // equal depth
        store(64'hBEEF_0000_0000_0123, 16'd300, 6'd20, src_pkg::BOUND_EXACT, 16'd3);
        probe(64'hBEEF_0000_0000_0123, 6'd0, 16'h0000, 16'h0000);
        control(src_pkg::KIND_NEWAGE);
        // older slot
        store(64'hCAFE_0000_0000_0123, 16'd400, 6'd1, src_pkg::BOUND_EXACT, 16'd4);
        probe(64'hCAFE_0000_0000_0123, 6'd1, 16'h0000, 16'h0000);
        // same age, kept
        store(64'hBEEF_0000_0000_0123, 16'd500, 6'd0, src_pkg::BOUND_EXACT, 16'd5);
        probe(64'hBEEF_0000_0000_0123, 6'd0, 16'h0000, 16'h0000);
    endtask

    // A run of new searches; an entry from an earlier search gives way
    task automatic test_age_steps();
        idle_en = 1'b0;
        store(64'h0000_1111_0000_0456, 16'd7, 6'd30, src_pkg::BOUND_EXACT, 16'd11);
        repeat (20) control(src_pkg::KIND_NEWAGE);
        // older, replaced
        store(64'h0000_2222_0000_0456, 16'd8, 6'd1, src_pkg::BOUND_EXACT, 16'd12);
        probe(64'h0000_2222_0000_0456, 6'd1, 16'h0000, 16'h0000);
        // same age, kept
        store(64'h0000_3333_0000_0456, 16'd9, 6'd0, src_pkg::BOUND_EXACT, 16'd13);
        probe(64'h0000_2222_0000_0456, 6'd0, 16'h0000, 16'h0000);
        probe(64'h0000_3333_0000_0456, 6'd0, 16'h0000, 16'h0000);
        idle_en = 1'b1;
    endtask

    // Clear empties the table and resets the age
    task automatic test_clear();
        control(src_pkg::KIND_CLEAR);
        probe(64'h0000_2222_0000_0456, 6'd0, 16'h0000, 16'h0000);
        probe(64'd0, 6'd0, 16'h0000, 16'h0000);
        store(64'h7777_0000_0000_0789, 16'd21, 6'd30, src_pkg::BOUND_EXACT, 16'd31);
        // same age, kept
        store(64'h8888_0000_0000_0789, 16'd22, 6'd1, src_pkg::BOUND_EXACT, 16'd32);
        control(src_pkg::KIND_NEWAGE);
        // older, replaced
        store(64'h8888_0000_0000_0789, 16'd23, 6'd1, src_pkg::BOUND_EXACT, 16'd33);
        probe(64'h8888_0000_0000_0789, 6'd0, 16'h0000, 16'h0000);
    endtask

    // Mixed traffic on colliding keys, mostly stores and probes
    task automatic test_random_traffic();
        int               r;
        logic [63:0]      key;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            idle_en = (n < RAND_ITEMS - CALM_ITEMS);
            r = $urandom_range(0, 999);
            if (r < 6) begin
                control(src_pkg::KIND_CLEAR);
            end else if (r < 80) begin
                control(src_pkg::KIND_NEWAGE);
            end else if (r < 540) begin
                key = ($urandom_range(0, 2) == 0) ? last_store_key : rand_key();
                probe(key, rand_depth(), rand_score(), rand_score());
            end else begin
                store(rand_key(), rand_score(), rand_depth(), 2'($urandom), 16'($urandom));
            end
        end
    endtask

    // Receiver: ready stretches and stall bursts, none once idling is off
    always @(posedge aclk) begin
        if (!idle_en) begin
            m_tready <= 1'b1;
            rx_left = 0;
        end else if (rx_left > 0) begin
            rx_left--;
        end else if ($urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            rx_left = $urandom_range(1, 17) - 1;
        end else begin
            m_tready <= 1'b1;
            rx_left = $urandom_range(0, 24);
        end
    end

    // Compare each result item with the oldest queued reply
    always @(posedge aclk) begin
        probe_reply_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pending_replies.size() == 0) begin
                $display("%0t: result item with none expected, data %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_replies.pop_front();
                replies_checked++;
                if (got.cutoff !== want.cutoff) begin
                    $display("%0t: cutoff expected %0b actual %0b",
                             $time, want.cutoff, got.cutoff);
                    errors++;
                end
                if (got.found_score !== want.found_score) begin
                    $display("%0t: found_score expected %0d actual %0d",
                             $time, want.found_score, got.found_score);
                    errors++;
                end
                if (got.move_found !== want.move_found) begin
                    $display("%0t: move_found expected %0b actual %0b",
                             $time, want.move_found, got.move_found);
                    errors++;
                end
                if (got.found_move !== want.found_move) begin
                    $display("%0t: found_move expected %h actual %h",
                             $time, want.found_move, got.found_move);
                    errors++;
                end
            end
        end
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: run limit hit, %0d replies still queued",
                     $time, pending_replies.size());
            $display("tb: done, errors");
            $finish;
        end
    end

    initial begin
        wipe_shadow();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_probes();
        test_bounds_and_extremes();
        test_zero_key();
        test_replacement();
        test_age_steps();
        test_clear();
        test_random_traffic();

        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("tb: %0d items sent, %0d probe replies checked, %0d table clears",
                 items_sent, replies_checked, clears_done);
        $display("tb: covered bound codes, key zero, depth/age replacement, search age steps");
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
